### src/assert_macros.svh
// Assertion macros for the port checker of the step and speed detector.
// No dependencies; include by bare file name before the module that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while the given reset is high.
`define ASCD_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Concurrent assertion that is checked on every edge, reset included.
`define ASCD_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/ascd_pkg.sv
// Shared types and constants of the step and speed detector.
// No dependencies; imported by every module of the block.
package ascd_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int THRESHOLD_W  = 15;
   localparam int REFRACTORY_W = 8;
   localparam int TIMEOUT_W    = 16;
   localparam int GAIN_W       = 16;
   localparam int COUNTER_W    = 16;
   localparam int STEP_TOTAL_W = 32;
   localparam int SPEED_W      = 16;
   localparam int INTEGRAL_W   = 40;
   localparam int MUL_SPLIT    = 20;
   localparam int PART_PROD_W  = MUL_SPLIT + GAIN_W;
   localparam int PRODUCT_W    = INTEGRAL_W + GAIN_W;
   localparam int SPEED_SHIFT  = 21;

   // Samples kept per axis between items: the newest and the middle one.
   localparam int WINDOW_LENGTH = 3;
   localparam int WINDOW_KEEP   = WINDOW_LENGTH - 1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_PEAK_THRESHOLD     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REFRACTORY_SAMPLES = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_SAMPLES    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_VELOCITY_GAIN      = 3'd3;

   localparam logic [THRESHOLD_W-1:0]  RESET_PEAK_THRESHOLD = 15'd1229;
   localparam logic [REFRACTORY_W-1:0] RESET_REFRACTORY     = 8'd20;
   localparam logic [TIMEOUT_W-1:0]    RESET_TIMEOUT        = 16'd300;
   localparam logic [GAIN_W-1:0]       RESET_GAIN           = 16'd6423;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   typedef struct packed {
      logic [THRESHOLD_W-1:0]  peak_threshold;
      logic [REFRACTORY_W-1:0] refractory_samples;
      logic [TIMEOUT_W-1:0]    timeout_samples;
      logic [GAIN_W-1:0]       velocity_gain;
   } csr_type;

   // One classified sample on its way from the front to the back.
   typedef struct packed {
      logic                       phase_one_hit;
      logic                       phase_two_hit;
      logic signed [SAMPLE_W-1:0] accel_z;
   } cmd_type;

   typedef struct packed {
      logic                    step_detected;
      logic [STEP_TOTAL_W-1:0] step_total;
      logic [SPEED_W-1:0]      speed_q8_8;
      logic                    speed_updated;
   } rsp_type;

endpackage

### src/accel_step_and_speed_detector.sv
// Step and speed detector top level: settings registers, front, queues and back.
// Depends on ascd_pkg, ascd_front, ascd_cmd_fifo, ascd_back and ascd_rsp_fifo.
// A sample's result passes the command queue, back end and result queue in turn.
// Throughput: one sample per cycle while neither queue is full; a step with a
// nonzero integral holds the back end in its multiply and finish states.
// Reset clears the queues and detection state and restores register defaults.
module accel_step_and_speed_detector (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_push,
   output logic                                    req_full,
   input  logic signed [ascd_pkg::SAMPLE_W-1:0]    req_accel_z,
   input  logic signed [ascd_pkg::SAMPLE_W-1:0]    req_accel_y,
   output logic                                    rsp_empty,
   input  logic                                    rsp_pop,
   output logic                                    rsp_step_detected,
   output logic [ascd_pkg::STEP_TOTAL_W-1:0]       rsp_step_total,
   output logic [ascd_pkg::SPEED_W-1:0]            rsp_speed_q8_8,
   output logic                                    rsp_speed_updated,
   input  logic                                    csr_we,
   input  logic [ascd_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [ascd_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import ascd_pkg::*;

   // The front stage keeps the last two Z and Y samples, finds the window
   // peaks and reduces each sample to two phase flags plus the raw Z value.
   // Those go through a short command queue to the back stage, which owns the
   // step pattern, the counters, the integral and the speed. Results land in
   // a result queue, so either side may stall without blocking the other.

   csr_type csr_ff, csr_in;
   cmd_type cmd_wdata, cmd_head;
   rsp_type rsp_wdata, rsp_head;
   logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic    rsp_push, rsp_full;

   // Settings writes; an index past the register list is ignored.
   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PEAK_THRESHOLD:     csr_in.peak_threshold     = csr_wdata[THRESHOLD_W-1:0];
            CSR_REFRACTORY_SAMPLES: csr_in.refractory_samples = csr_wdata[REFRACTORY_W-1:0];
            CSR_TIMEOUT_SAMPLES:    csr_in.timeout_samples    = csr_wdata[TIMEOUT_W-1:0];
            CSR_VELOCITY_GAIN:      csr_in.velocity_gain      = csr_wdata[GAIN_W-1:0];
            default:                csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.peak_threshold     <= RESET_PEAK_THRESHOLD;
         csr_ff.refractory_samples <= RESET_REFRACTORY;
         csr_ff.timeout_samples    <= RESET_TIMEOUT;
         csr_ff.velocity_gain      <= RESET_GAIN;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // A transfer on the input side happens when req_push is high and req_full low.
   ascd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr_ff),
      .push     (req_push),
      .accel_z  (req_accel_z),
      .accel_y  (req_accel_y),
      .full     (req_full),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd_data (cmd_wdata)
   );

   ascd_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_wdata),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .head      (cmd_head),
      .empty     (cmd_empty)
   );

   // The back stage only takes a sample when the result queue has room, so a
   // result held across the multiply always finds a free slot.
   ascd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .cmd_head  (cmd_head),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_wdata)
   );

   // A result transfer happens when rsp_pop is high and rsp_empty low.
   ascd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_wdata),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .head      (rsp_head),
      .empty     (rsp_empty)
   );

   assign rsp_step_detected = rsp_head.step_detected;
   assign rsp_step_total    = rsp_head.step_total;
   assign rsp_speed_q8_8    = rsp_head.speed_q8_8;
   assign rsp_speed_updated = rsp_head.speed_updated;

endmodule

### src/ascd_cmd_fifo.sv
// Short queue of classified samples between the front and the back.
// Depends on ascd_pkg for the entry type and the queue depth.
module ascd_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ascd_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output ascd_pkg::cmd_type head,
   output logic             empty
);
   import ascd_pkg::*;

   localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);

   cmd_type                store_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign full    = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### src/ascd_rsp_fifo.sv
// Result queue that presents the oldest finished result to the consumer.
// Depends on ascd_pkg for the result type and the queue depth.
module ascd_rsp_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ascd_pkg::rsp_type push_data,
   output logic             full,
   input  logic             pop,
   output ascd_pkg::rsp_type head,
   output logic             empty
);
   import ascd_pkg::*;

   localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);

   rsp_type                store_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign full    = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### src/ascd_front.sv
// Front end: keeps the per-axis sample windows and classifies each sample.
// Depends on ascd_pkg; feeds ascd_cmd_fifo.
module ascd_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ascd_pkg::csr_type                     csr,
   input  logic                                 push,
   input  logic signed [ascd_pkg::SAMPLE_W-1:0] accel_z,
   input  logic signed [ascd_pkg::SAMPLE_W-1:0] accel_y,
   output logic                                 full,
   input  logic                                 cmd_full,
   output logic                                 cmd_push,
   output ascd_pkg::cmd_type                     cmd_data
);
   import ascd_pkg::*;

   // Index 0 holds the newest stored sample, index 1 the one before it.
   logic signed [SAMPLE_W-1:0] window_z_ff [WINDOW_KEEP];
   logic signed [SAMPLE_W-1:0] window_y_ff [WINDOW_KEEP];
   logic                       accept;
   logic                       peak_z, peak_y;
   logic signed [SAMPLE_W-1:0] threshold;

   // The middle sample is a peak at or above the threshold and above both neighbors.
   function automatic logic is_peak(input logic signed [SAMPLE_W-1:0] newest,
                                    input logic signed [SAMPLE_W-1:0] middle,
                                    input logic signed [SAMPLE_W-1:0] oldest,
                                    input logic signed [SAMPLE_W-1:0] level);
      return (middle >= level) && (middle > oldest) && (middle > newest);
   endfunction

   assign threshold = $signed({1'b0, csr.peak_threshold});
   assign accept    = push & ~cmd_full;
   assign full      = cmd_full;
   assign cmd_push  = accept;

   assign peak_z = is_peak(accel_z, window_z_ff[0], window_z_ff[1], threshold);
   assign peak_y = is_peak(accel_y, window_y_ff[0], window_y_ff[1], threshold);

   always_comb begin
      cmd_data.phase_one_hit = peak_z & window_y_ff[0][SAMPLE_W-1];
      cmd_data.phase_two_hit = peak_y & (window_y_ff[0] > window_z_ff[0]);
      cmd_data.accel_z       = accel_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_KEEP; i++) begin
            window_z_ff[i] <= SAMPLE_MIN;
            window_y_ff[i] <= SAMPLE_MIN;
         end
      end else if (accept) begin
         window_z_ff[0] <= accel_z;
         window_y_ff[0] <= accel_y;
         for (int i = 1; i < WINDOW_KEEP; i++) begin
            window_z_ff[i] <= window_z_ff[i-1];
            window_y_ff[i] <= window_y_ff[i-1];
         end
      end
   end

endmodule

### src/ascd_back.sv
// Back end: step pattern tracking, integration, timeout and speed scaling.
// Depends on ascd_pkg; drains ascd_cmd_fifo and fills ascd_rsp_fifo.
module ascd_back (
   input  logic              clock,
   input  logic              reset,
   input  ascd_pkg::csr_type  csr,
   input  ascd_pkg::cmd_type  cmd_head,
   input  logic              cmd_empty,
   output logic              cmd_pop,
   input  logic              rsp_full,
   output logic              rsp_push,
   output ascd_pkg::rsp_type  rsp_data
);
   import ascd_pkg::*;

   typedef enum logic [1:0] {ST_RUN, ST_MUL_LO, ST_MUL_HI, ST_FINISH} state_type;

   state_type                  state_ff, state_in;
   logic [COUNTER_W-1:0]       since_step_ff, since_step_in;
   logic                       phase_one_ff, phase_one_in;
   logic                       phase_two_ff, phase_two_in;
   logic [STEP_TOTAL_W-1:0]    step_count_ff, step_count_in;
   logic signed [SAMPLE_W-1:0] previous_z_ff, previous_z_in;
   logic [INTEGRAL_W-1:0]      integral_ff, integral_in;
   logic [SPEED_W-1:0]         speed_ff, speed_in;
   logic [COUNTER_W-1:0]       since_update_ff, since_update_in;
   logic [INTEGRAL_W-1:0]      mul_a_ff, mul_a_in;
   logic [PART_PROD_W-1:0]     prod_lo_ff, prod_lo_in;
   logic [PART_PROD_W-1:0]     prod_hi_ff, prod_hi_in;
   rsp_type                    held_ff, held_in;

   logic                       take;
   logic [COUNTER_W-1:0]       since_step_inc, since_update_inc;
   logic                       phase_one_set, phase_two_set, pattern, refractory, step;
   logic                       z_pos, prev_pos;
   logic [SAMPLE_W:0]          add_term;
   logic [INTEGRAL_W:0]        integral_sum;
   logic [INTEGRAL_W-1:0]      integral_acc;
   logic                       timeout_hit, start_mul;
   logic [STEP_TOTAL_W-1:0]    count_next;
   logic [SPEED_W-1:0]         speed_after_timeout;
   logic [MUL_SPLIT-1:0]       mul_operand;
   logic [PART_PROD_W-1:0]     mul_product;
   logic [PRODUCT_W-1:0]       product_full;
   logic [PRODUCT_W-SPEED_SHIFT-1:0] product_scaled;
   logic [SPEED_W-1:0]         speed_sat;

   assign take = (state_ff == ST_RUN) & ~cmd_empty & ~rsp_full;

   assign since_step_inc   = (&since_step_ff) ? since_step_ff : since_step_ff + 1'b1;
   assign since_update_inc = (&since_update_ff) ? since_update_ff : since_update_ff + 1'b1;

   assign phase_one_set = phase_one_ff | cmd_head.phase_one_hit;
   assign phase_two_set = phase_two_ff | (phase_one_set & cmd_head.phase_two_hit);
   assign pattern       = phase_one_set & phase_two_set;
   assign refractory    = since_step_inc < COUNTER_W'(csr.refractory_samples);
   assign step          = pattern & ~refractory;

   assign count_next = (step && !(&step_count_ff)) ? step_count_ff + 1'b1 : step_count_ff;

   // Trapezoid sum of two positive samples, saturating at the integral's maximum.
   assign z_pos        = ~cmd_head.accel_z[SAMPLE_W-1] & (|cmd_head.accel_z);
   assign prev_pos     = ~previous_z_ff[SAMPLE_W-1] & (|previous_z_ff);
   assign add_term     = {1'b0, cmd_head.accel_z} + {1'b0, previous_z_ff};
   assign integral_sum = {1'b0, integral_ff} + (INTEGRAL_W+1)'(add_term);
   assign integral_acc = integral_sum[INTEGRAL_W] ? '1 : integral_sum[INTEGRAL_W-1:0];

   assign timeout_hit         = (since_update_inc > csr.timeout_samples) && (speed_ff != '0);
   assign speed_after_timeout = timeout_hit ? '0 : speed_ff;
   assign start_mul           = step && (integral_ff != '0);

   // One shared 20x16 multiplier works through the integral in two halves.
   assign mul_operand    = (state_ff == ST_MUL_HI) ? mul_a_ff[INTEGRAL_W-1:MUL_SPLIT]
                                                   : mul_a_ff[MUL_SPLIT-1:0];
   assign mul_product    = PART_PROD_W'(mul_operand) * PART_PROD_W'(csr.velocity_gain);
   assign product_full   = {prod_hi_ff, MUL_SPLIT'(0)} + PRODUCT_W'(prod_lo_ff);
   assign product_scaled = product_full[PRODUCT_W-1:SPEED_SHIFT];
   assign speed_sat      = (|product_scaled[PRODUCT_W-SPEED_SHIFT-1:SPEED_W]) ? '1
                                                   : product_scaled[SPEED_W-1:0];

   always_comb begin
      state_in        = state_ff;
      since_step_in   = since_step_ff;
      phase_one_in    = phase_one_ff;
      phase_two_in    = phase_two_ff;
      step_count_in   = step_count_ff;
      previous_z_in   = previous_z_ff;
      integral_in     = integral_ff;
      speed_in        = speed_ff;
      since_update_in = since_update_ff;
      mul_a_in        = mul_a_ff;
      prod_lo_in      = prod_lo_ff;
      prod_hi_in      = prod_hi_ff;
      held_in         = held_ff;
      cmd_pop         = 1'b0;
      rsp_push        = 1'b0;
      rsp_data        = held_ff;

      case (state_ff)
         ST_RUN: begin
            if (take) begin
               cmd_pop         = 1'b1;
               since_step_in   = step ? '0 : since_step_inc;
               phase_one_in    = phase_one_set & ~pattern & ~timeout_hit;
               phase_two_in    = phase_two_set & ~pattern & ~timeout_hit;
               step_count_in   = count_next;
               since_update_in = since_update_inc;
               speed_in        = speed_after_timeout;
               if (!step) begin
                  previous_z_in = cmd_head.accel_z;
                  if (z_pos && prev_pos) begin
                     integral_in = integral_acc;
                  end
               end
               if (start_mul) begin
                  integral_in           = '0;
                  since_update_in       = '0;
                  mul_a_in              = integral_ff;
                  held_in.step_detected = 1'b1;
                  held_in.step_total    = count_next;
                  held_in.speed_q8_8    = speed_after_timeout;
                  held_in.speed_updated = 1'b1;
                  state_in              = ST_MUL_LO;
               end else begin
                  rsp_push               = 1'b1;
                  rsp_data.step_detected = step;
                  rsp_data.step_total    = count_next;
                  rsp_data.speed_q8_8    = speed_after_timeout;
                  rsp_data.speed_updated = timeout_hit;
               end
            end
         end
         ST_MUL_LO: begin
            prod_lo_in = mul_product;
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            prod_hi_in = mul_product;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            speed_in            = speed_sat;
            rsp_push            = 1'b1;
            rsp_data.speed_q8_8 = speed_sat;
            state_in            = ST_RUN;
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mul_a_ff   <= mul_a_in;
      prod_lo_ff <= prod_lo_in;
      prod_hi_ff <= prod_hi_in;
      held_ff    <= held_in;
      if (reset) begin
         state_ff        <= ST_RUN;
         since_step_ff   <= '0;
         phase_one_ff    <= 1'b0;
         phase_two_ff    <= 1'b0;
         step_count_ff   <= '0;
         previous_z_ff   <= '0;
         integral_ff     <= '0;
         speed_ff        <= '0;
         since_update_ff <= '0;
      end else begin
         state_ff        <= state_in;
         since_step_ff   <= since_step_in;
         phase_one_ff    <= phase_one_in;
         phase_two_ff    <= phase_two_in;
         step_count_ff   <= step_count_in;
         previous_z_ff   <= previous_z_in;
         integral_ff     <= integral_in;
         speed_ff        <= speed_in;
         since_update_ff <= since_update_in;
      end
   end

endmodule

### src/ascd_checker.sv
// Port-level checks of the step and speed detector, bound to its top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ascd_port_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_push,
   input logic               req_full,
   input logic signed [15:0] req_accel_z,
   input logic signed [15:0] req_accel_y,
   input logic               rsp_empty,
   input logic               rsp_pop,
   input logic               rsp_step_detected,
   input logic [31:0]        rsp_step_total,
   input logic [15:0]        rsp_speed_q8_8,
   input logic               rsp_speed_updated,
   input logic               csr_we,
   input logic [2:0]         csr_index,
   input logic [15:0]        csr_wdata
);

   // Reset leaves the result queue empty and the command queue with room.
   `ASCD_ASSERT(a_reset_empties, clock, reset |=> rsp_empty && !req_full, "queues not empty after reset")

   // A waiting result is not withdrawn before its transfer.
   `ASCD_ASSERT_RST(a_rsp_kept, clock, reset, !rsp_empty && !rsp_pop |=> !rsp_empty, "result dropped")

   // A step always shows a nonzero total.
   `ASCD_ASSERT_RST(a_step_total, clock, reset, !rsp_empty && rsp_step_detected |-> rsp_step_total != 32'd0, "step with zero total")

   // Without a step, a speed update can only be the timeout clearing the speed.
   `ASCD_ASSERT_RST(a_timeout_clears, clock, reset, !rsp_empty && rsp_speed_updated && !rsp_step_detected |-> rsp_speed_q8_8 == 16'd0, "timeout left speed")

endmodule

bind accel_step_and_speed_detector ascd_port_checker u_checker (.*);

### sim/ascd_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the step and speed detector: watches the sample, result and register
// ports, predicts every result and compares it field by field. Depends on ascd_pkg.
module ascd_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   input  logic                                 req_full,
   input  logic signed [ascd_pkg::SAMPLE_W-1:0] req_accel_z,
   input  logic signed [ascd_pkg::SAMPLE_W-1:0] req_accel_y,
   input  logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   input  logic                                 rsp_step_detected,
   input  logic [ascd_pkg::STEP_TOTAL_W-1:0]    rsp_step_total,
   input  logic [ascd_pkg::SPEED_W-1:0]         rsp_speed_q8_8,
   input  logic                                 rsp_speed_updated,
   input  logic                                 csr_we,
   input  logic [ascd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ascd_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output int                                   mismatch_total,
   output int                                   results_pending
);
   import ascd_pkg::*;

   localparam int REPORT_LIMIT = 10;
   localparam logic [INTEGRAL_W-1:0]   INTEGRAL_FULL   = '1;
   localparam logic [COUNTER_W-1:0]    COUNTER_FULL    = '1;
   localparam logic [STEP_TOTAL_W-1:0] STEP_TOTAL_FULL = '1;
   localparam logic [SPEED_W-1:0]      SPEED_FULL      = '1;

   csr_type                    cfg;
   logic signed [SAMPLE_W-1:0] win_z [WINDOW_LENGTH];
   logic signed [SAMPLE_W-1:0] win_y [WINDOW_LENGTH];
   logic [COUNTER_W-1:0]       since_last_step;
   logic [COUNTER_W-1:0]       since_speed_change;
   logic                       vertical_armed;
   logic                       forward_armed;
   logic [STEP_TOTAL_W-1:0]    steps_counted;
   logic signed [SAMPLE_W-1:0] last_z;
   logic [INTEGRAL_W-1:0]      z_area;
   logic [SPEED_W-1:0]         speed_now;
   rsp_type                    predicted_results [$];
   int                         errors_seen;

   function automatic logic middle_is_peak(input logic signed [SAMPLE_W-1:0] older,
                                           input logic signed [SAMPLE_W-1:0] middle,
                                           input logic signed [SAMPLE_W-1:0] newer);
      return int'(middle) >= int'(cfg.peak_threshold) && middle > older && middle > newer;
   endfunction

   // Advances the detector state by one sample and returns the result it yields.
   function automatic rsp_type advance_detector(input logic signed [SAMPLE_W-1:0] z,
                                                input logic signed [SAMPLE_W-1:0] y);
      rsp_type               r;
      logic                  hit_z;
      logic                  hit_y;
      logic                  stepped;
      logic                  refreshed;
      logic [INTEGRAL_W-1:0] pair_sum;
      logic [PRODUCT_W-1:0]  product;
      stepped   = 1'b0;
      refreshed = 1'b0;
      for (int i = WINDOW_LENGTH - 1; i > 0; i--) begin
         win_z[i] = win_z[i-1];
         win_y[i] = win_y[i-1];
      end
      win_z[0] = z;
      win_y[0] = y;
      hit_z = middle_is_peak(win_z[2], win_z[1], win_z[0]);
      hit_y = middle_is_peak(win_y[2], win_y[1], win_y[0]);

      if (since_last_step != COUNTER_FULL) since_last_step++;
      if (hit_z && win_y[1] < 0) vertical_armed = 1'b1;
      if (vertical_armed && hit_y && win_y[1] > win_z[1]) forward_armed = 1'b1;
      if (vertical_armed && forward_armed &&
          since_last_step < COUNTER_W'(cfg.refractory_samples)) begin
         vertical_armed = 1'b0;
         forward_armed  = 1'b0;
      end
      if (vertical_armed && forward_armed) begin
         since_last_step = '0;
         vertical_armed  = 1'b0;
         forward_armed   = 1'b0;
         if (steps_counted != STEP_TOTAL_FULL) steps_counted++;
         stepped = 1'b1;
      end

      if (!stepped) begin
         if (z > 0 && last_z > 0) begin
            pair_sum = INTEGRAL_W'($unsigned(z)) + INTEGRAL_W'($unsigned(last_z));
            if (z_area > INTEGRAL_FULL - pair_sum) z_area = INTEGRAL_FULL;
            else z_area = z_area + pair_sum;
         end
         last_z = z;
      end

      if (since_speed_change != COUNTER_FULL) since_speed_change++;
      if (since_speed_change > cfg.timeout_samples && speed_now != '0) begin
         speed_now      = '0;
         vertical_armed = 1'b0;
         forward_armed  = 1'b0;
         refreshed      = 1'b1;
      end

      if (stepped && z_area != '0) begin
         product   = PRODUCT_W'(z_area) * PRODUCT_W'(cfg.velocity_gain);
         product   = product >> SPEED_SHIFT;
         speed_now = (product > PRODUCT_W'(SPEED_FULL)) ? SPEED_FULL : product[SPEED_W-1:0];
         z_area    = '0;
         since_speed_change = '0;
         refreshed = 1'b1;
      end

      r.step_detected = stepped;
      r.step_total    = steps_counted;
      r.speed_q8_8    = speed_now;
      r.speed_updated = refreshed;
      return r;
   endfunction

   always @(posedge clock) begin : watch_ports
      rsp_type seen;
      rsp_type want;
      if (reset) begin
         cfg.peak_threshold     = RESET_PEAK_THRESHOLD;
         cfg.refractory_samples = RESET_REFRACTORY;
         cfg.timeout_samples    = RESET_TIMEOUT;
         cfg.velocity_gain      = RESET_GAIN;
         for (int i = 0; i < WINDOW_LENGTH; i++) begin
            win_z[i] = SAMPLE_MIN;
            win_y[i] = SAMPLE_MIN;
         end
         since_last_step    = '0;
         since_speed_change = '0;
         vertical_armed     = 1'b0;
         forward_armed      = 1'b0;
         steps_counted      = '0;
         last_z             = '0;
         z_area             = '0;
         speed_now          = '0;
         predicted_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PEAK_THRESHOLD:     cfg.peak_threshold     = csr_wdata[THRESHOLD_W-1:0];
               CSR_REFRACTORY_SAMPLES: cfg.refractory_samples = csr_wdata[REFRACTORY_W-1:0];
               CSR_TIMEOUT_SAMPLES:    cfg.timeout_samples    = csr_wdata[TIMEOUT_W-1:0];
               CSR_VELOCITY_GAIN:      cfg.velocity_gain      = csr_wdata[GAIN_W-1:0];
               default: ;
            endcase
         end
         if (req_push && !req_full) begin
            predicted_results.insert(predicted_results.size(),
                                     advance_detector(req_accel_z, req_accel_y));
         end
         if (rsp_pop && !rsp_empty) begin
            seen.step_detected = rsp_step_detected;
            seen.step_total    = rsp_step_total;
            seen.speed_q8_8    = rsp_speed_q8_8;
            seen.speed_updated = rsp_speed_updated;
            if (predicted_results.size() == 0) begin
               errors_seen++;
               if (errors_seen <= REPORT_LIMIT) begin
                  $display("%0t: result transfer with no prediction waiting", $time);
               end
            end else begin
               want = predicted_results.pop_front();
               if (want.step_detected !== seen.step_detected ||
                   want.step_total !== seen.step_total ||
                   want.speed_q8_8 !== seen.speed_q8_8 ||
                   want.speed_updated !== seen.speed_updated) begin
                  errors_seen++;
                  if (errors_seen <= REPORT_LIMIT) begin
                     $display("%0t: mismatch step/total/speed/updated want %0b/%0d/%0d/%0b",
                              $time, want.step_detected, want.step_total, want.speed_q8_8,
                              want.speed_updated);
                     $display("   got %0b/%0d/%0d/%0b", seen.step_detected, seen.step_total,
                              seen.speed_q8_8, seen.speed_updated);
                  end
               end
            end
         end
      end
      mismatch_total  <= errors_seen;
      results_pending <= predicted_results.size();
   end

endmodule

### sim/tb_accel_step_and_speed_detector.sv
`timescale 1ns / 1ps
// Top of the step and speed detector testbench: clock, reset, sample stimulus and verdict.
// Depends on ascd_pkg, accel_step_and_speed_detector and the ascd_checker scoreboard.
module tb_accel_step_and_speed_detector;
   import ascd_pkg::*;

   // The cycle limit is far above the slowest correct run, even with every
   // step running the speed multiply under stalls.
   localparam int RESET_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 1_000_000;
   // Extra wait after the last result for the queues and speed multiplier to settle.
   localparam int DRAIN_SLACK  = 6;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_push = 1'b0;
   logic                         req_full;
   logic signed [SAMPLE_W-1:0]   req_accel_z = '0;
   logic signed [SAMPLE_W-1:0]   req_accel_y = '0;
   logic                         rsp_empty;
   logic                         rsp_pop = 1'b0;
   logic                         rsp_step_detected;
   logic [STEP_TOTAL_W-1:0]      rsp_step_total;
   logic [SPEED_W-1:0]           rsp_speed_q8_8;
   logic                         rsp_speed_updated;
   logic                         csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]        csr_wdata = '0;

   int mismatch_total;
   int results_pending;
   int samples_sent = 0;
   int cycles_run = 0;
   int push_gap_pct = 0;
   int pop_stall_pct = 0;
   int cur_threshold = int'(RESET_PEAK_THRESHOLD);
   int cur_refractory = int'(RESET_REFRACTORY);

   accel_step_and_speed_detector dut (.*);

   // The scoreboard sits beside the block and sees every transfer on its ports.
   ascd_checker scoreboard (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycles_run <= cycles_run + 1;
      if (cycles_run == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // The result side stalls at random; pop_stall_pct sets the stall chance in percent.
   always @(posedge clock) begin
      rsp_pop <= !reset && ($urandom_range(99, 0) >= push_gap_pct * 0 + pop_stall_pct);
   end

   // Offers one sample and holds it until the block takes the transfer. Before
   // the offer the sender may sit idle, each cycle with the chance in percent of push_gap_pct.
   // push stays high between back-to-back samples so that no edge sees a drop.
   task automatic push_sample(input int z, input int y);
      while ($urandom_range(99, 0) < push_gap_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push    <= 1'b1;
      req_accel_z <= SAMPLE_W'(z);
      req_accel_y <= SAMPLE_W'(y);
      do @(posedge clock); while (req_full);
      samples_sent++;
   endtask

   // Stops offering samples and waits until every predicted result has been
   // popped, then lets the multiplier and output stages settle.
   task automatic settle();
      req_push <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   // One register write. The enable drops after each write so that two
   // writes in a row never assign the enable twice in the same time step.
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // The user must change registers only while the block is idle; the block does not enforce it, so drain first.
   task automatic set_config(input int threshold, input int refractory, input int timeout,
                             input int gain);
      settle();
      csr_write(CSR_PEAK_THRESHOLD, threshold);
      csr_write(CSR_REFRACTORY_SAMPLES, refractory);
      csr_write(CSR_TIMEOUT_SAMPLES, timeout);
      csr_write(CSR_VELOCITY_GAIN, gain);
      cur_threshold  = threshold;
      cur_refractory = refractory;
   endtask

   // A random level below the given one, but not too far below, so that the
   // peaks built from it stay realistic.
   function automatic int random_below(input int top);
      int lo;
      lo = (top - 6000 < -32768) ? -32768 : top - 6000;
      return lo + int'($urandom_range(top - 1 - lo, 0));
   endfunction

   // Vertical level between peaks: positive to feed the integral, or at or
   // below zero in a dry stride so that the next step sees an empty integral.
   function automatic int filler_z(input bit dry);
      return dry ? -int'($urandom_range(3000, 0)) : int'($urandom_range(8000, 1));
   endfunction

   // Forward level while the vertical peak is on: always negative.
   function automatic int negative_y();
      if ($urandom_range(15, 0) == 0) return -32768;
      return -1 - int'($urandom_range(8000, 0));
   endfunction

   // A fixed stride that always ends in an accepted step once the refractory
   // count has passed: positive filler, a vertical peak with the forward axis
   // negative, then a forward peak above the vertical level.
   task automatic send_fixed_step();
      repeat (6) push_sample(5000, 0);
      push_sample(500, -100);
      push_sample(4000, -100);
      push_sample(500, -100);
      push_sample(500, 0);
      push_sample(500, 4000);
      push_sample(500, 0);
   endtask

   // One stride of random content. Most strides are well formed: filler, a
   // vertical peak while the forward axis is negative, then a forward peak.
   // Some lose their forward half, and the rest are plain noise over the full
   // sample range.
   task automatic send_stride();
      int  filler;
      int  z_peak;
      int  y_peak;
      bit  dry;
      if ($urandom_range(199, 0) == 0) settle();
      if ($urandom_range(99, 0) < 15) begin
         repeat ($urandom_range(8, 1)) push_sample(int'($urandom), int'($urandom));
         return;
      end
      dry    = ($urandom_range(5, 0) == 0);
      filler = $urandom_range(cur_refractory + 8, 0);
      repeat (filler) push_sample(filler_z(dry), int'($urandom_range(6000, 0)) - 3000);

      z_peak = $urandom_range(32767, cur_threshold);
      push_sample(dry ? filler_z(1'b1) : random_below(z_peak), negative_y());
      push_sample(z_peak, negative_y());
      push_sample(dry ? filler_z(1'b1) : random_below(z_peak), negative_y());

      if ($urandom_range(9, 0) != 0) begin
         y_peak = $urandom_range(32767, cur_threshold);
         push_sample(filler_z(dry), random_below(y_peak));
         push_sample(dry ? filler_z(1'b1) : random_below(y_peak), y_peak);
         push_sample(filler_z(dry), random_below(y_peak));
      end
   endtask

   task automatic run_strides(input int count);
      int target;
      target = samples_sent + count;
      while (samples_sent < target) send_stride();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed samples with the reset settings, no idling on either side.
      // Extremes of both axes first.
      push_sample(32767, 32767);
      push_sample(-32768, -32768);
      push_sample(32767, -32768);
      push_sample(-32768, 32767);
      push_sample(0, 0);
      // A vertical peak exactly at the threshold with the forward axis negative,
      // then a forward peak exactly at the threshold. The pair comes too soon
      // after reset, so the refractory count rejects it.
      push_sample(100, -500);
      push_sample(1229, -500);
      push_sample(100, -500);
      push_sample(100, 0);
      push_sample(100, 1229);
      push_sample(100, 0);
      // Equal neighbours never make a peak, since a peak must be strictly above.
      push_sample(2000, -9);
      push_sample(2000, -9);
      push_sample(2000, -9);
      // Enough samples have now passed for a step to be accepted.
      send_fixed_step();

      run_strides(150);

      // Low extremes of the settings with the largest gain. A zero timeout
      // clears the speed on the sample right after each refresh. Writes to the
      // indexes past the register list must leave the settings alone.
      set_config(0, 0, 0, 65535);
      for (int idx = int'(CSR_VELOCITY_GAIN) + 1; idx < (1 << CSR_INDEX_W); idx++) begin
         csr_write(CSR_INDEX_W'(idx), int'($urandom_range(65535, 0)));
      end
      run_strides(150);

      // High extremes: highest threshold, longest refractory and timeout, zero gain.
      set_config(32767, 255, 65535, 0);
      run_strides(100);

      // Random settings under each idling pattern: the sender idle, the
      // receiver stalling, and both at once at a lower rate.
      for (int phase = 1; phase < 4; phase++) begin
         settle();
         if (phase == 1) begin
            push_gap_pct  <= 46;
            pop_stall_pct <= 0;
         end else if (phase == 2) begin
            push_gap_pct  <= 0;
            pop_stall_pct <= 46;
         end else begin
            push_gap_pct  <= 10;
            pop_stall_pct <= 10;
         end
         set_config(int'($urandom_range(6000, 300)), int'($urandom_range(24, 0)),
                    int'($urandom_range(150, 0)), int'($urandom_range(65535, 0)));
         run_strides(250);
      end

      settle();
      repeat (DRAIN_SLACK) @(posedge clock);
      if (mismatch_total == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
